@@ rtl/pvsd_pkg.sv @@
// package for the prefix varint stream decoder
// shared widths, codes and structs; no dependencies
`default_nettype none

package pvsd_pkg;

    localparam int BYTE_W        = 8;
    localparam int VALUE_W       = 64;
    localparam int KIND_W        = 2;
    localparam int PEND_W        = 4;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 1;

    // largest plain-mode length byte that is accepted
    localparam logic [BYTE_W-1:0] MAX_LENGTH_BYTES = 8'd8;

    typedef enum logic [KIND_W-1:0] {
        KIND_PLAIN   = 2'd0,
        KIND_COUNT   = 2'd1,
        KIND_ELEMENT = 2'd2
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COMPRESSED_FORMAT = 1'd0,
        CFG_COUNTED_SEQUENCES = 1'd1
    } cfg_index_t;

    typedef struct packed {
        logic [PEND_W-1:0]  bytes_pending;
        logic [VALUE_W-1:0] accumulator;
        logic [VALUE_W-1:0] elements_left;
        logic               inside_group;
    } dec_state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        kind_t              kind;
        logic               last_of_group;
        logic               error;
    } dec_result_t;

endpackage

`default_nettype wire

@@ rtl/pvsd_channels.sv @@
// valid/ready channel interfaces for the decoder's byte input and result output
// depends on pvsd_pkg
`default_nettype none

interface pvsd_byte_if;
    logic                        valid;
    logic                        ready;
    logic [pvsd_pkg::BYTE_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface pvsd_result_if;
    logic                         valid;
    logic                         ready;
    logic [pvsd_pkg::VALUE_W-1:0] value;
    logic [pvsd_pkg::KIND_W-1:0]  kind;
    logic                         last_of_group;
    logic                         error;

    modport source (output valid, output value, output kind, output last_of_group,
                    output error, input ready);
    modport sink   (input valid, input value, input kind, input last_of_group,
                    input error, output ready);
endinterface

`default_nettype wire

@@ rtl/pvsd_decode_core.sv @@
// next-state and result logic for one byte of the varint stream
// depends on pvsd_pkg
`default_nettype none

module pvsd_decode_core
(
    input  wire logic                        compressed_format,
    input  wire logic                        counted_sequences,
    input  wire logic [pvsd_pkg::BYTE_W-1:0] byte_in,
    input  var  pvsd_pkg::dec_state_t        cur,
    output var  pvsd_pkg::dec_state_t        nxt,
    output logic                             emit,
    output var  pvsd_pkg::dec_result_t       res
);

    logic [pvsd_pkg::VALUE_W-1:0] acc_shift;
    logic [pvsd_pkg::VALUE_W-1:0] value_done;
    logic [pvsd_pkg::VALUE_W-1:0] elements_dec;
    logic                         err;

    assign acc_shift    = {cur.accumulator[pvsd_pkg::VALUE_W-pvsd_pkg::BYTE_W-1:0], byte_in};
    assign elements_dec = cur.elements_left - pvsd_pkg::VALUE_W'(1);

    always_comb
    begin
        nxt        = cur;
        emit       = 1'b0;
        err        = 1'b0;
        value_done = '0;

        priority if (cur.bytes_pending != '0)
        begin
            nxt.accumulator   = acc_shift;
            nxt.bytes_pending = cur.bytes_pending - pvsd_pkg::PEND_W'(1);
            if (cur.bytes_pending == pvsd_pkg::PEND_W'(1))
            begin
                emit       = 1'b1;
                value_done = acc_shift;
            end
        end
        else if (compressed_format)
        begin
            // lead byte: two-bit follow count, six value bits
            nxt.accumulator   = pvsd_pkg::VALUE_W'(byte_in[5:0]);
            nxt.bytes_pending = pvsd_pkg::PEND_W'(byte_in[7:6]);
            if (byte_in[7:6] == 2'd0)
            begin
                emit       = 1'b1;
                value_done = pvsd_pkg::VALUE_W'(byte_in[5:0]);
            end
        end
        else if (byte_in > pvsd_pkg::MAX_LENGTH_BYTES)
        begin
            // oversized length abandons any open group
            err               = 1'b1;
            nxt.accumulator   = '0;
            nxt.bytes_pending = '0;
            nxt.inside_group  = 1'b0;
            nxt.elements_left = '0;
        end
        else
        begin
            nxt.accumulator   = '0;
            nxt.bytes_pending = pvsd_pkg::PEND_W'(byte_in);
            emit              = (byte_in == '0);
        end

        res.value         = value_done;
        res.kind          = pvsd_pkg::KIND_PLAIN;
        res.last_of_group = 1'b0;
        res.error         = err;

        if (emit)
        begin
            nxt.accumulator   = '0;
            nxt.bytes_pending = '0;
            if (cur.inside_group)
            begin
                res.kind          = pvsd_pkg::KIND_ELEMENT;
                nxt.elements_left = elements_dec;
                if (elements_dec == '0)
                begin
                    res.last_of_group = 1'b1;
                    nxt.inside_group  = 1'b0;
                end
            end
            else if (counted_sequences)
            begin
                res.kind = pvsd_pkg::KIND_COUNT;
                if (value_done == '0)
                begin
                    res.last_of_group = 1'b1;
                end
                else
                begin
                    nxt.inside_group  = 1'b1;
                    nxt.elements_left = value_done;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/prefix_varint_stream_decoder_unit.sv @@
// top level of the prefix varint stream decoder
// a byte that completes an integer, or an oversized length, shows its result in the cycle after acceptance
// throughput: one byte per cycle while results are taken
// a waiting result holds the byte input; a result taken frees it in the same cycle
// reset: compressed format on, counted sequences off, decoder state and output valid cleared
// depends on pvsd_pkg, pvsd_channels and pvsd_decode_core
`default_nettype none

module prefix_varint_stream_decoder_unit
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pvsd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pvsd_pkg::CFG_DATA_W-1:0]  cfg_data,
    pvsd_byte_if.sink                             byte_stream,
    pvsd_result_if.source                         result_stream
);

    logic                  compressed_format_reg;
    logic                  counted_sequences_reg;
    pvsd_pkg::dec_state_t  state_reg;
    pvsd_pkg::dec_state_t  state_next;
    pvsd_pkg::dec_result_t res_next;
    pvsd_pkg::dec_result_t res_reg;
    logic                  out_valid_reg;
    logic                  emit;
    logic                  accept;

    assign byte_stream.ready = !out_valid_reg || result_stream.ready;
    assign accept            = byte_stream.valid && byte_stream.ready;

    pvsd_decode_core u_core
    (
        .compressed_format (compressed_format_reg),
        .counted_sequences (counted_sequences_reg),
        .byte_in           (byte_stream.byte_in),
        .cur               (state_reg),
        .nxt               (state_next),
        .emit              (emit),
        .res               (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compressed_format_reg <= 1'b1;
            counted_sequences_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pvsd_pkg::CFG_COMPRESSED_FORMAT: compressed_format_reg <= cfg_data[0];
                pvsd_pkg::CFG_COUNTED_SEQUENCES: counted_sequences_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (accept && (emit || res_next.error))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (emit || res_next.error))
        begin
            res_reg <= res_next;
        end
    end

    assign result_stream.valid         = out_valid_reg;
    assign result_stream.value         = res_reg.value;
    assign result_stream.kind          = res_reg.kind;
    assign result_stream.last_of_group = res_reg.last_of_group;
    assign result_stream.error         = res_reg.error;

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bytes_pending <= pvsd_pkg::PEND_W'(pvsd_pkg::MAX_LENGTH_BYTES))
        else $error("bytes pending beyond the longest integer");

    a_group_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.inside_group |-> (state_reg.elements_left != '0))
        else $error("open group with no elements left");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.error) |->
            (res_reg.value == '0 && res_reg.kind == pvsd_pkg::KIND_PLAIN
             && !res_reg.last_of_group))
        else $error("error item carries data");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit) |=> out_valid_reg)
        else $error("completed integer produced no item");

    a_zero_count_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.kind == pvsd_pkg::KIND_COUNT && res_reg.last_of_group)
            |-> (res_reg.value == '0))
        else $error("count marked last but not zero");

endmodule

`default_nettype wire

@@ test/tb_prefix_varint_stream_decoder_unit.sv @@
`timescale 1ns / 1ps
// self-checking testbench for prefix_varint_stream_decoder_unit: queue-fed driver,
// checking monitor and an in-bench decoder predictor
// depends on pvsd_pkg, pvsd_channels and the decoder rtl

module tb_prefix_varint_stream_decoder_unit;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                            cfg_we    = 1'b0;
    pvsd_pkg::cfg_index_t            cfg_index = pvsd_pkg::CFG_COMPRESSED_FORMAT;
    logic [pvsd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic                        in_valid  = 1'b0;
    logic [pvsd_pkg::BYTE_W-1:0] in_byte   = '0;
    logic                        out_ready = 1'b0;

    pvsd_byte_if   byte_ch ();
    pvsd_result_if res_ch ();

    assign byte_ch.valid   = in_valid;
    assign byte_ch.byte_in = in_byte;
    assign res_ch.ready    = out_ready;

    prefix_varint_stream_decoder_unit u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .byte_stream   (byte_ch),
        .result_stream (res_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // bytes waiting for the driver and decoded integers waiting for the monitor
    logic [pvsd_pkg::BYTE_W-1:0] byte_q[$];
    pvsd_pkg::dec_result_t       decoded_q[$];

    // predictor state, reset values as after rst_n
    logic                         fmt_compressed = 1'b1;
    logic                         seq_counted    = 1'b0;
    logic [pvsd_pkg::PEND_W-1:0]  pend           = '0;
    logic [pvsd_pkg::VALUE_W-1:0] acc            = '0;
    logic [pvsd_pkg::VALUE_W-1:0] elems_left     = '0;
    logic                         in_group       = 1'b0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int unsigned bytes_taken   = 0;
    int unsigned n_results     = 0;
    int unsigned n_counts      = 0;
    int unsigned n_elements    = 0;
    int unsigned n_len_errors  = 0;
    int unsigned mismatches    = 0;

    function automatic void finish_integer(logic [pvsd_pkg::VALUE_W-1:0] v);
        pvsd_pkg::dec_result_t r;
        r.value         = v;
        r.kind          = pvsd_pkg::KIND_PLAIN;
        r.last_of_group = 1'b0;
        r.error         = 1'b0;
        if (in_group)
        begin
            r.kind     = pvsd_pkg::KIND_ELEMENT;
            elems_left = elems_left - pvsd_pkg::VALUE_W'(1);
            if (elems_left == '0)
            begin
                r.last_of_group = 1'b1;
                in_group        = 1'b0;
            end
        end
        else if (seq_counted)
        begin
            r.kind = pvsd_pkg::KIND_COUNT;
            if (v == '0)
                r.last_of_group = 1'b1;
            else
            begin
                in_group   = 1'b1;
                elems_left = v;
            end
        end
        acc  = '0;
        pend = '0;
        decoded_q.push_back(r);
    endfunction

    function automatic void decode_byte(logic [pvsd_pkg::BYTE_W-1:0] b);
        pvsd_pkg::dec_result_t r;
        if (pend != '0)
        begin
            acc  = {acc[pvsd_pkg::VALUE_W-pvsd_pkg::BYTE_W-1:0], b};
            pend = pend - pvsd_pkg::PEND_W'(1);
            if (pend == '0)
                finish_integer(acc);
        end
        else if (fmt_compressed)
        begin
            acc  = {{(pvsd_pkg::VALUE_W-6){1'b0}}, b[5:0]};
            pend = {{(pvsd_pkg::PEND_W-2){1'b0}}, b[7:6]};
            if (pend == '0)
                finish_integer(acc);
        end
        else if (b > pvsd_pkg::MAX_LENGTH_BYTES)
        begin
            // oversized length drops any open group
            acc             = '0;
            pend            = '0;
            in_group        = 1'b0;
            elems_left      = '0;
            r.value         = '0;
            r.kind          = pvsd_pkg::KIND_PLAIN;
            r.last_of_group = 1'b0;
            r.error         = 1'b1;
            decoded_q.push_back(r);
        end
        else
        begin
            acc  = '0;
            pend = b[pvsd_pkg::PEND_W-1:0];
            if (pend == '0)
                finish_integer('0);
        end
    endfunction

    task automatic report_mismatch(string what, logic [pvsd_pkg::VALUE_W-1:0] got,
                                   logic [pvsd_pkg::VALUE_W-1:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                     n_results, what, got, want);
    endtask

    task automatic check_result();
        pvsd_pkg::dec_result_t want;
        if (decoded_q.size() == 0)
        begin
            report_mismatch("result with nothing pending, value", res_ch.value, '0);
            return;
        end
        want = decoded_q.pop_front();
        if (res_ch.value !== want.value)
            report_mismatch("value", res_ch.value, want.value);
        if (res_ch.kind !== want.kind)
            report_mismatch("kind", res_ch.kind, want.kind);
        if (res_ch.last_of_group !== want.last_of_group)
            report_mismatch("last_of_group", res_ch.last_of_group, want.last_of_group);
        if (res_ch.error !== want.error)
            report_mismatch("error", res_ch.error, want.error);
        n_results++;
        if (want.error)
            n_len_errors++;
        else if (want.kind == pvsd_pkg::KIND_COUNT)
            n_counts++;
        else if (want.kind == pvsd_pkg::KIND_ELEMENT)
            n_elements++;
    endtask

    // driver: predicts on acceptance, then offers the next byte or idles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && byte_ch.ready)
            begin
                decode_byte(in_byte);
                bytes_taken++;
            end
            if (!in_valid || byte_ch.ready)
            begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_byte  <= byte_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && out_ready)
                check_result();
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        @(negedge clk);
        while (byte_q.size() != 0 || in_valid || decoded_q.size() != 0)
            @(negedge clk);
        // an incomplete integer gives nothing to wait for, so let the pipeline settle
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(pvsd_pkg::cfg_index_t idx, logic [pvsd_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            pvsd_pkg::CFG_COMPRESSED_FORMAT: fmt_compressed = val[0];
            pvsd_pkg::CFG_COUNTED_SEQUENCES: seq_counted    = val[0];
            default: ;
        endcase
    endtask

    function automatic void push_integer(logic compressed);
        int unsigned len;
        int unsigned fill;
        logic [pvsd_pkg::BYTE_W-1:0] lead;
        logic [pvsd_pkg::BYTE_W-1:0] b;
        fill = $urandom_range(7);
        lead = pvsd_pkg::BYTE_W'($urandom);
        if (compressed)
        begin
            len = $urandom_range(3);
            if (fill == 0)
                lead = 8'hff;
            else if (fill == 1)
                lead = 8'h00;
            lead[7:6] = len[1:0];
            byte_q.push_back(lead);
        end
        else
        begin
            len = ($urandom_range(3) == 0) ? 8 : $urandom_range(8);
            byte_q.push_back(len[7:0]);
        end
        repeat (len)
        begin
            b = pvsd_pkg::BYTE_W'($urandom);
            if (fill == 0)
                b = 8'hff;
            else if (fill == 1)
                b = 8'h00;
            byte_q.push_back(b);
        end
    endfunction

    function automatic void push_count(logic compressed, int unsigned cnt);
        if (compressed)
            byte_q.push_back({2'b00, cnt[5:0]});
        else if (cnt == 0 && $urandom_range(1) == 0)
            byte_q.push_back(8'h00);
        else
        begin
            byte_q.push_back(8'h01);
            byte_q.push_back(cnt[7:0]);
        end
    endfunction

    // mostly well-formed integers or groups, with some stray bytes (not in compressed counted mode) and short groups
    function automatic void fill_stream(logic compressed, logic counted, int unsigned nbytes);
        int unsigned goal;
        int unsigned cnt;
        int unsigned k;
        logic [pvsd_pkg::BYTE_W-1:0] b;
        goal = byte_q.size() + nbytes;
        while (byte_q.size() < goal)
        begin
            if ((!compressed || !counted) && $urandom_range(11) == 0)
            begin
                b = pvsd_pkg::BYTE_W'($urandom);
                byte_q.push_back(b);
            end
            else if (counted)
            begin
                cnt = $urandom_range(4);
                k   = cnt;
                if (cnt != 0 && $urandom_range(7) == 0)
                    k = cnt - 1;
                push_count(compressed, cnt);
                repeat (k) push_integer(compressed);
            end
            else
                push_integer(compressed);
        end
    endfunction

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 37;
        recv_idle_pct = 84;

        // compressed leads of every prefix length, extremes of the six-bit top
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h3f);
        byte_q.push_back(8'h7f); byte_q.push_back(8'hff);
        byte_q.push_back(8'h40); byte_q.push_back(8'h00);
        byte_q.push_back(8'hbf); byte_q.push_back(8'hff); byte_q.push_back(8'hff);
        byte_q.push_back(8'hff); byte_q.push_back(8'hff);
        byte_q.push_back(8'hff); byte_q.push_back(8'hff);
        // format switched with one byte still owed
        byte_q.push_back(8'h80); byte_q.push_back(8'h12);
        wait_drained();
        write_reg(pvsd_pkg::CFG_COMPRESSED_FORMAT, 1'b0);
        byte_q.push_back(8'h34);

        // plain lengths: empty, widest at all ones, oversized, single byte
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h08);
        repeat (8) byte_q.push_back(8'hff);
        byte_q.push_back(8'h09);
        byte_q.push_back(8'h01); byte_q.push_back(8'h80);
        wait_drained();

        // counted groups: zero count, error dropping a group, sequences off mid-group
        write_reg(pvsd_pkg::CFG_COUNTED_SEQUENCES, 1'b1);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h01); byte_q.push_back(8'h02);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h09);
        byte_q.push_back(8'h01); byte_q.push_back(8'h01);
        wait_drained();
        write_reg(pvsd_pkg::CFG_COUNTED_SEQUENCES, 1'b0);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h00);

        for (int unsigned phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 37; recv_idle_pct = 84; end
                1: begin send_idle_pct = 84; recv_idle_pct = 37; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int unsigned mode = 0; mode < 4; mode++)
            begin
                wait_drained();
                write_reg(pvsd_pkg::CFG_COMPRESSED_FORMAT, mode[0]);
                write_reg(pvsd_pkg::CFG_COUNTED_SEQUENCES, mode[1]);
                fill_stream(mode[0], mode[1], 33);
                // hold the sender back until every result is in
                wait_drained();
                fill_stream(mode[0], mode[1], 33);
            end
        end
        wait_drained();

        $display("run covered %0d bytes and %0d decoded results", bytes_taken, n_results);
        $display("of which %0d group counts, %0d group elements, %0d length errors",
                 n_counts, n_elements, n_len_errors);
        if (mismatches == 0)
            $display("tb_prefix_varint_stream_decoder_unit: clean");
        else
            $display("tb_prefix_varint_stream_decoder_unit: errors");
        $finish;
    end

    initial
    begin
        #400000;
        $display("timeout with %0d results still pending", decoded_q.size());
        $display("tb_prefix_varint_stream_decoder_unit: errors");
        $finish;
    end

endmodule
